// File: rtl/core/emfd_pkg.sv
// ============================================================================
// emfd_pkg
// Types and constants shared by the EM4100 Manchester frame decoder.
// ============================================================================
package emfd_pkg;

    localparam int unsigned TICK_W         = 16;
    localparam int unsigned ID_W           = 32;
    localparam int unsigned STATUS_W       = 3;
    localparam int unsigned DATA_BITS      = 55;
    localparam int unsigned HEADER_ONES    = 9;
    localparam int unsigned HEADER_SEARCH  = 64;
    localparam int unsigned PREAMBLE_PAIRS = 16;
    localparam int unsigned DATA_ROWS      = 10;
    localparam int unsigned ID_ROW_FIRST   = 2;
    localparam int unsigned STEP_W         = 7;
    localparam int unsigned ONES_W         = 4;
    localparam int unsigned CFG_IDX_W      = 1;

    localparam logic [STEP_W-1:0] STEP_MAX     = '1;
    localparam logic [STEP_W-1:0] HDR_LIMIT    = STEP_W'(HEADER_SEARCH);
    localparam logic [STEP_W-1:0] PRE_LIMIT    = STEP_W'(PREAMBLE_PAIRS);
    localparam logic [STEP_W-1:0] DATA_LIMIT   = STEP_W'(DATA_BITS);
    localparam logic [ONES_W-1:0] ONES_LIMIT   = ONES_W'(HEADER_ONES);

    localparam logic [TICK_W-1:0] THR_RESET    = 16'd384;
    localparam logic [TICK_W-1:0] TMO_RESET    = 16'd768;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 1'b0,
        CFG_TIMEOUT   = 1'b1
    } t_cfg_idx;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_TIMEOUT   = 3'd1,
        ST_NO_HEADER = 3'd2,
        ST_ROW_PAR   = 3'd3,
        ST_COL_STOP  = 3'd4
    } t_frame_status;

    typedef struct packed {
        logic              line_level;
        logic [TICK_W-1:0] interval_ticks;
    } t_line_item;

    typedef struct packed {
        t_frame_status   frame_status;
        logic [ID_W-1:0] card_id;
    } t_frame_result;

endpackage

// File: rtl/core/emfd_stream_if.sv
// ============================================================================
// emfd_stream_if
// Valid/ready stream channel carrying one payload per transfer.
// ============================================================================
interface emfd_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/core/em4100_manchester_frame_decoder.sv
// ============================================================================
// em4100_manchester_frame_decoder
// Manchester frame decoder for 125 kHz EM4100-style proximity cards.
// ============================================================================
// Usage:
//   i_line  : one measured line interval per transfer (level, length in ticks).
//   o_frame : one transfer per frame, a status and the 32-bit card ID
//             (ID is zero unless the status is ok).
//   i_cfg_* : threshold (index 0) and timeout (index 1), written while idle.
// Throughput: one interval per clock while o_frame is not stalled; an interval
//   is held in the input register, decoded against the frame state, and any
//   result lands in the output register.
// Result: valid from the output register once the interval that completes
//   the frame has been taken from the input register and decoded.
// Reset: preamble search, no pending half-bit, threshold 384, timeout 768.
// Stall: while o_frame holds a result that is not taken, the held interval
//   waits in the input register and i_line drops ready once that is full.
// ============================================================================
module em4100_manchester_frame_decoder
    import emfd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [TICK_W-1:0]    i_cfg_wdata,
    emfd_stream_if.sink          i_line,
    emfd_stream_if.source        o_frame
);

    typedef enum logic [1:0] {
        PH_PRE  = 2'd0,
        PH_HDR  = 2'd1,
        PH_DATA = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        PEND_NONE = 2'd0,
        PEND_THR  = 2'd1,
        PEND_TMO  = 2'd2
    } t_pend;

    logic [TICK_W-1:0]    r_thr, r_tmo;
    logic                 r_in_valid;
    t_line_item           r_in_item;
    logic                 r_out_valid;
    t_frame_result        r_out;

    t_phase               r_phase, n_phase;
    logic [STEP_W-1:0]    r_step, n_step;
    logic [ONES_W-1:0]    r_ones, n_ones;
    logic                 r_last, n_last;
    t_pend                r_pend, n_pend;
    logic [DATA_BITS-1:0] r_store, n_store;

    logic                 w_proc;
    logic                 w_emit;
    t_frame_status        w_status;
    logic [ID_W-1:0]      w_id;

    assign w_proc       = r_in_valid && (!r_out_valid || o_frame.ready);
    assign i_line.ready = !r_in_valid || w_proc;
    assign o_frame.valid   = r_out_valid;
    assign o_frame.payload = r_out;

    always_comb begin
        logic [TICK_W-1:0] v_t;
        logic              v_lvl;
        logic [TICK_W-1:0] v_limit;
        logic              v_short;
        logic              v_bit;
        logic              v_done;
        logic [STEP_W-1:0] v_step_inc;
        logic [4:0]        v_row;
        logic [3:0]        v_col;
        logic              v_row_err;
        logic [ID_W-1:0]   v_id;
        logic [4:0]        v_tail;

        v_t        = r_in_item.interval_ticks;
        v_lvl      = r_in_item.line_level;
        v_limit    = (r_pend == PEND_THR) ? r_thr : r_tmo;
        v_short    = (v_t <= r_thr);
        v_bit      = 1'b0;
        v_done     = 1'b0;
        v_step_inc = (r_step == STEP_MAX) ? r_step : r_step + STEP_W'(1);
        v_row      = '0;
        v_col      = '0;
        v_row_err  = 1'b0;
        v_id       = '0;
        v_tail     = '0;

        n_phase  = r_phase;
        n_step   = r_step;
        n_ones   = r_ones;
        n_last   = r_last;
        n_pend   = r_pend;
        n_store  = r_store;
        w_emit   = 1'b0;
        w_status = ST_OK;
        w_id     = '0;

        unique case (r_phase)
            PH_HDR, PH_DATA: begin
                if (r_pend != PEND_NONE) begin
                    if (v_lvl == !r_last) begin
                        if (v_t > v_limit) begin
                            w_emit   = 1'b1;
                            w_status = ST_TIMEOUT;
                        end else begin
                            n_pend = PEND_NONE;
                            v_done = 1'b1;
                        end
                    end
                end else if (v_lvl == r_last) begin
                    if (v_t > r_tmo) begin
                        w_emit   = 1'b1;
                        w_status = ST_TIMEOUT;
                    end else begin
                        v_bit  = r_last ? !v_short : v_short;
                        n_last = !v_bit;
                        if (v_short) begin
                            n_pend = (r_phase == PH_DATA && !v_bit) ? PEND_TMO : PEND_THR;
                        end else begin
                            v_done = 1'b1;
                        end
                    end
                end

                if (v_done) begin
                    v_bit  = !n_last;
                    n_step = v_step_inc;
                    if (r_phase == PH_HDR) begin
                        if (v_bit) begin
                            n_ones = r_ones + ONES_W'(1);
                            if (n_ones >= ONES_LIMIT) begin
                                n_phase = PH_DATA;
                                n_step  = '0;
                                n_ones  = '0;
                            end
                        end else begin
                            n_ones = '0;
                            if (v_step_inc >= HDR_LIMIT) begin
                                w_emit   = 1'b1;
                                w_status = ST_NO_HEADER;
                            end
                        end
                    end else begin
                        n_store = {r_store[DATA_BITS-2:0], v_bit};
                        if (v_step_inc >= DATA_LIMIT) begin
                            for (int r = 0; r < DATA_ROWS; r++) begin
                                v_row     = n_store[DATA_BITS-5-5*r +: 5];
                                v_row_err = v_row_err | (^v_row);
                                v_col     = v_col ^ v_row[4:1];
                                if (r >= ID_ROW_FIRST) begin
                                    v_id = {v_id[ID_W-5:0], v_row[4:1]};
                                end
                            end
                            v_tail = n_store[4:0];
                            w_emit = 1'b1;
                            if (v_row_err) begin
                                w_status = ST_ROW_PAR;
                            end else if (v_tail[4:1] != v_col || v_tail[0]) begin
                                w_status = ST_COL_STOP;
                            end else begin
                                w_status = ST_OK;
                                w_id     = v_id;
                            end
                        end
                    end
                end
            end
            default: begin
                if (v_lvl == (r_pend == PEND_NONE)) begin
                    if (v_t > r_tmo) begin
                        w_emit   = 1'b1;
                        w_status = ST_TIMEOUT;
                    end else if (r_pend == PEND_NONE) begin
                        n_pend = PEND_THR;
                    end else begin
                        n_pend = PEND_NONE;
                        n_step = v_step_inc;
                        if (v_t >= r_thr || v_step_inc >= PRE_LIMIT) begin
                            n_phase = PH_HDR;
                            n_last  = 1'b1;
                            n_step  = '0;
                            n_ones  = '0;
                        end
                    end
                end
            end
        endcase

        if (w_emit) begin
            n_phase = PH_PRE;
            n_step  = '0;
            n_ones  = '0;
            n_last  = 1'b1;
            n_pend  = PEND_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= THR_RESET;
            r_tmo       <= TMO_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_PRE;
            r_step      <= '0;
            r_ones      <= '0;
            r_last      <= 1'b1;
            r_pend      <= PEND_NONE;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_THRESHOLD: r_thr <= i_cfg_wdata;
                    CFG_TIMEOUT:   r_tmo <= i_cfg_wdata;
                    default:       ;
                endcase
            end
            if (i_line.ready) begin
                r_in_valid <= i_line.valid;
            end
            if (w_proc) begin
                r_phase <= n_phase;
                r_step  <= n_step;
                r_ones  <= n_ones;
                r_last  <= n_last;
                r_pend  <= n_pend;
            end
            if (w_proc && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_frame.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_line.ready && i_line.valid) begin
            r_in_item <= i_line.payload;
        end
        if (w_proc) begin
            r_store <= n_store;
        end
        if (w_proc && w_emit) begin
            r_out.frame_status <= w_status;
            r_out.card_id      <= w_id;
        end
    end

    a_fail_id_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.frame_status != ST_OK |-> r_out.card_id == '0)
        else $error("card ID not cleared on failed frame");

    a_ones_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ones < ONES_LIMIT)
        else $error("header ones run past limit");

    a_pre_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PRE |-> r_pend != PEND_TMO)
        else $error("timeout-held half-bit in preamble");

    a_emit_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_proc && w_emit |=> r_phase == PH_PRE && r_pend == PEND_NONE && r_out_valid)
        else $error("decoder not restarted after result");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_proc |=> r_in_valid && $stable(r_in_item))
        else $error("held interval lost while output stalled");

endmodule

// File: dv/tb_em4100_manchester_frame_decoder.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_em4100_manchester_frame_decoder
// Self-checking bench for the EM4100 Manchester frame decoder. Line intervals
// are queued as whole card frames: preamble, header and data, some of them
// broken by parity, stop, timeout or header faults, plus line noise. A
// behavioural decoder predicts each frame transfer, which the monitor
// checks field by field. Both channels idle at random except in the last
// phase, over several threshold and timeout settings.
// ============================================================================
module tb_em4100_manchester_frame_decoder
    import emfd_pkg::*;
();

    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASES      = 8;

    typedef enum logic [1:0] {DP_PREAMBLE, DP_HEADER, DP_DATA} t_dec_phase;
    typedef enum logic [1:0] {HALF_NONE, HALF_THR, HALF_TMO} t_half;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [TICK_W-1:0]    i_cfg_wdata = '0;

    emfd_stream_if #(.t_payload(t_line_item))    line_if ();
    emfd_stream_if #(.t_payload(t_frame_result)) frame_if ();

    em4100_manchester_frame_decoder u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_line      (line_if),
        .o_frame     (frame_if)
    );

    always #10 i_clk = ~i_clk;

    // decoder shadow
    logic [TICK_W-1:0] thr_reg = THR_RESET;
    logic [TICK_W-1:0] tmo_reg = TMO_RESET;
    t_dec_phase        dec_phase = DP_PREAMBLE;
    logic [STEP_W-1:0] dec_steps = '0;
    logic [ONES_W-1:0] dec_ones = '0;
    logic              dec_level = 1'b1;
    t_half             dec_half = HALF_NONE;
    logic [DATA_BITS-1:0] dec_bits = '0;

    t_line_item    pending_lines[$];
    t_frame_result frames_due[$];
    t_frame_result due_frame;

    logic gen_lvl = 1'b1;
    bit   calm = 1'b0;
    int   stray_pct = 0;
    int   lines_pushed = 0;
    int   lines_real = 0;
    int   lines_taken = 0;
    int   err_cnt = 0;
    int   cycle_cnt = 0;

    logic [TICK_W-1:0] thr_plan[PHASES] = '{16'd384, 16'd0, 16'd1000, 16'd65534,
                                            16'd65535, 16'd0, 16'd1, 16'd384};
    logic [TICK_W-1:0] tmo_plan[PHASES] = '{16'd768, 16'd65535, 16'd3000, 16'd65535,
                                            16'd0, 16'd0, 16'd2, 16'd768};

    function automatic void dec_restart();
        dec_phase = DP_PREAMBLE;
        dec_steps = '0;
        dec_ones  = '0;
        dec_level = 1'b1;
        dec_half  = HALF_NONE;
    endfunction

    function automatic void frame_done(t_frame_status st, logic [ID_W-1:0] id);
        t_frame_result r;
        r.frame_status = st;
        r.card_id      = id;
        frames_due.push_back(r);
        dec_restart();
    endfunction

    function automatic void close_frame();
        logic [4:0]      row;
        logic [3:0]      col;
        logic [ID_W-1:0] id;
        bit              bad_row;
        col = '0;
        id = '0;
        bad_row = 1'b0;
        for (int r = 0; r < DATA_ROWS; r++) begin
            row = dec_bits[50 - 5*r +: 5];
            if (^row)
                bad_row = 1'b1;
            col ^= row[4:1];
            if (r >= ID_ROW_FIRST)
                id = {id[ID_W-5:0], row[4:1]};
        end
        if (bad_row)
            frame_done(ST_ROW_PAR, '0);
        else if (dec_bits[4:1] != col || dec_bits[0])
            frame_done(ST_COL_STOP, '0);
        else
            frame_done(ST_OK, id);
    endfunction

    function automatic void finish_decision();
        logic b;
        b = ~dec_level;
        if (dec_steps < STEP_MAX)
            dec_steps++;
        if (dec_phase == DP_HEADER) begin
            if (b) begin
                dec_ones++;
                if (dec_ones >= ONES_LIMIT) begin
                    dec_phase = DP_DATA;
                    dec_steps = '0;
                    dec_ones  = '0;
                end
            end else begin
                dec_ones = '0;
                if (dec_steps >= HDR_LIMIT)
                    frame_done(ST_NO_HEADER, '0);
            end
        end else begin
            dec_bits = {dec_bits[DATA_BITS-2:0], b};
            if (dec_steps >= DATA_LIMIT)
                close_frame();
        end
    endfunction

    function automatic void decode_interval(t_line_item it);
        logic              lvl;
        logic [TICK_W-1:0] t;
        logic [TICK_W-1:0] lim;
        logic              is_short;
        logic              b;
        lvl = it.line_level;
        t   = it.interval_ticks;
        if (dec_phase != DP_PREAMBLE) begin
            if (dec_half != HALF_NONE) begin
                lim = (dec_half == HALF_THR) ? thr_reg : tmo_reg;
                if (lvl == dec_level)
                    return;
                if (t > lim) begin
                    frame_done(ST_TIMEOUT, '0);
                    return;
                end
                dec_half = HALF_NONE;
                finish_decision();
                return;
            end
            if (lvl != dec_level)
                return;
            if (t > tmo_reg) begin
                frame_done(ST_TIMEOUT, '0);
                return;
            end
            is_short  = (t <= thr_reg);
            b         = dec_level ? ~is_short : is_short;
            dec_level = ~b;
            if (is_short) begin
                dec_half = (dec_phase == DP_DATA && !b) ? HALF_TMO : HALF_THR;
                return;
            end
            finish_decision();
            return;
        end
        if (lvl != (dec_half == HALF_NONE))
            return;
        if (t > tmo_reg) begin
            frame_done(ST_TIMEOUT, '0);
            return;
        end
        if (dec_half == HALF_NONE) begin
            dec_half = HALF_THR;
            return;
        end
        dec_half = HALF_NONE;
        if (dec_steps < STEP_MAX)
            dec_steps++;
        if (t >= thr_reg || dec_steps >= PRE_LIMIT) begin
            dec_phase = DP_HEADER;
            dec_level = 1'b1;
            dec_steps = '0;
            dec_ones  = '0;
        end
    endfunction

    // value in [lo, hi], with the two ends favoured
    function automatic logic [TICK_W-1:0] pick(int unsigned lo, int unsigned hi);
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return TICK_W'(lo);
        if (r == 1)
            return TICK_W'(hi);
        return TICK_W'($urandom_range(hi, lo));
    endfunction

    function automatic logic [TICK_W-1:0] over_tmo();
        return pick(32'(tmo_reg) + 1, 65535);
    endfunction

    // occasionally precede with an interval at the level the decoder ignores
    function automatic void push_line(logic lvl, logic [TICK_W-1:0] t);
        t_line_item it;
        if ($urandom_range(0, 99) < stray_pct) begin
            it.line_level     = ~lvl;
            it.interval_ticks = pick(0, 65535);
            pending_lines.push_back(it);
            lines_pushed++;
        end
        it.line_level     = lvl;
        it.interval_ticks = t;
        pending_lines.push_back(it);
        lines_pushed++;
        lines_real++;
    endfunction

    // cut_how: 0 clean, 1 timeout on the leading interval, 2 on the trailing half
    task automatic push_bit(logic b, bit in_data, int cut_how);
        if (b == gen_lvl) begin
            push_line(gen_lvl, cut_how != 0 ? over_tmo() : pick(32'(thr_reg) + 1, tmo_reg));
            gen_lvl = ~gen_lvl;
        end else if (cut_how == 1) begin
            push_line(gen_lvl, over_tmo());
        end else begin
            push_line(gen_lvl, pick(0, thr_reg));
            if (cut_how == 2)
                push_line(~gen_lvl, (in_data && !b) ? over_tmo()
                                                    : pick(32'(thr_reg) + 1, 65535));
            else
                push_line(~gen_lvl, (in_data && !b) ? pick(0, tmo_reg) : pick(0, thr_reg));
        end
    endtask

    task automatic queue_preamble();
        int n;
        if (thr_reg != 0 && $urandom_range(0, 3) == 0) begin
            repeat (PREAMBLE_PAIRS) begin
                push_line(1'b1, pick(0, tmo_reg));
                push_line(1'b0, pick(0, 32'(thr_reg) - 1));
            end
        end else begin
            n = (thr_reg == 0) ? 1 : $urandom_range(1, PREAMBLE_PAIRS);
            repeat (n - 1) begin
                push_line(1'b1, pick(0, tmo_reg));
                push_line(1'b0, pick(0, 32'(thr_reg) - 1));
            end
            push_line(1'b1, pick(0, tmo_reg));
            push_line(1'b0, pick(thr_reg, tmo_reg));
        end
        gen_lvl = 1'b1;
    endtask

    task automatic queue_sequence();
        int                   kind;
        int                   cut_at;
        int                   cut_how;
        int                   run;
        int                   k;
        int                   fill;
        int                   data_start;
        logic                 b;
        logic [DATA_BITS-1:0] word;
        logic [3:0]           nib;
        logic [3:0]           col;
        logic                 seq[$];
        kind = $urandom_range(0, 99);
        if (thr_reg >= tmo_reg || kind >= 90) begin
            repeat ($urandom_range(5, 30))
                push_line(1'($urandom_range(0, 1)), pick(0, 65535));
            // one of the two always lands on the expected level and aborts
            if (tmo_reg != 16'hFFFF) begin
                push_line(1'b1, 16'hFFFF);
                push_line(1'b0, 16'hFFFF);
            end
            return;
        end
        if (kind >= 72 && kind < 82 && tmo_reg == 16'hFFFF)
            kind = 0;
        queue_preamble();
        if (kind >= 82) begin
            run = 0;
            k = 0;
            do begin
                k++;
                b = (run < 8) && ($urandom_range(0, 2) == 0);
                run = b ? run + 1 : 0;
                push_bit(b, 1'b0, 0);
            end while (b || k < HEADER_SEARCH);
            return;
        end
        fill = $urandom_range(0, 9);
        col = '0;
        for (int r = 0; r < DATA_ROWS; r++) begin
            case (fill)
                0: nib = 4'h0;
                1: nib = 4'hF;
                default: nib = 4'($urandom);
            endcase
            col ^= nib;
            word[54 - 5*r -: 4] = nib;
            word[50 - 5*r] = ^nib;
        end
        word[4:1] = col;
        word[0] = 1'b0;
        if (kind >= 45 && kind < 55)
            word[$urandom_range(5, 54)] ^= 1'b1;
        else if (kind >= 55 && kind < 63)
            word[$urandom_range(1, 4)] ^= 1'b1;
        else if (kind >= 63 && kind < 72)
            word[0] = 1'b1;
        run = 0;
        k = $urandom_range(0, 12);
        for (int i = 0; i < k; i++) begin
            b = (run < 8) && ($urandom_range(0, 1) == 1) && (i != k - 1);
            run = b ? run + 1 : 0;
            seq.push_back(b);
        end
        repeat (HEADER_ONES)
            seq.push_back(1'b1);
        data_start = seq.size();
        for (int i = DATA_BITS - 1; i >= 0; i--)
            seq.push_back(word[i]);
        cut_at = (kind >= 72 && kind < 82) ? $urandom_range(0, seq.size() - 1) : -1;
        cut_how = $urandom_range(1, 2);
        foreach (seq[i]) begin
            if (i == cut_at) begin
                push_bit(seq[i], i >= data_start, cut_how);
                return;
            end
            push_bit(seq[i], i >= data_start, 0);
        end
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [TICK_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_THRESHOLD)
            thr_reg = val;
        else
            tmo_reg = val;
    endtask

    task automatic wait_drained();
        while (lines_taken != lines_pushed || frames_due.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // line driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            line_if.valid <= 1'b0;
        end else begin
            if (line_if.valid && line_if.ready) begin
                decode_interval(line_if.payload);
                lines_taken++;
            end
            if (!line_if.valid || line_if.ready) begin
                if (pending_lines.size() != 0 && (calm || $urandom_range(0, 99) >= 31)) begin
                    line_if.valid   <= 1'b1;
                    line_if.payload <= pending_lines.pop_front();
                end else begin
                    line_if.valid <= 1'b0;
                end
            end
        end
    end

    // frame monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_if.ready <= 1'b0;
        end else begin
            if (frame_if.valid && frame_if.ready) begin
                if (frames_due.size() == 0) begin
                    $error("unexpected frame transfer: status %0d, card_id %h",
                           frame_if.payload.frame_status, frame_if.payload.card_id);
                    err_cnt++;
                end else begin
                    due_frame = frames_due.pop_front();
                    if (frame_if.payload.frame_status !== due_frame.frame_status) begin
                        $error("frame_status: expected %0d, got %0d",
                               due_frame.frame_status, frame_if.payload.frame_status);
                        err_cnt++;
                    end
                    if (frame_if.payload.card_id !== due_frame.card_id) begin
                        $error("card_id: expected %h, got %h",
                               due_frame.card_id, frame_if.payload.card_id);
                        err_cnt++;
                    end
                end
            end
            frame_if.ready <= calm || ($urandom_range(0, 99) >= 31);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("em4100_manchester_frame_decoder test failed");
            $finish;
        end
    end

    initial begin
        int base_lines;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            if (p == 5) begin
                thr_plan[p] = TICK_W'($urandom_range(0, 20000));
                tmo_plan[p] = TICK_W'($urandom_range(32'(thr_plan[p]) + 1, 40000));
            end
            if (p != 0) begin
                write_reg(CFG_THRESHOLD, thr_plan[p]);
                write_reg(CFG_TIMEOUT, tmo_plan[p]);
            end
            calm = (p == PHASES - 1);
            if (p == 0) begin
                stray_pct = 0;
                push_line(1'b0, 16'h0000);
                push_line(1'b1, 16'hFFFF);
                push_line(1'b1, 16'h0000);
                push_line(1'b0, 16'd768);
                push_line(1'b0, 16'd5);
                push_line(1'b1, 16'd769);
                push_line(1'b1, 16'd384);
                push_line(1'b0, 16'd384);
                push_line(1'b1, 16'd385);
                push_line(1'b0, 16'd10);
                push_line(1'b0, 16'd10);
                push_line(1'b1, 16'd385);
                push_line(1'b0, 16'd700);
            end
            stray_pct = 4;
            base_lines = lines_real;
            while (lines_real - base_lines < 200) begin
                queue_sequence();
                while (pending_lines.size() > 16)
                    @(posedge i_clk);
            end
        end
        wait_drained();
        if (err_cnt == 0)
            $display("em4100_manchester_frame_decoder test passed");
        else
            $display("em4100_manchester_frame_decoder test failed");
        $finish;
    end

endmodule
